// ===== hdl/cooc_pkg.sv =====
`default_nettype none

package cooc_pkg;

	localparam int HASH_BITS_DEF = 256;
	localparam int WORD_W        = 64;
	localparam int NUM_WORDS     = 4;
	localparam int FIELD_POS_W   = 8;
	localparam int COUNT_W       = 8;
	localparam int TDATA_W       = NUM_WORDS * WORD_W + 2 * FIELD_POS_W;
	localparam int TUSER_W       = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// index unit status toward the counter stage
	typedef struct packed {
		logic valid;
		logic query;
		logic busy;
	} idx_stat_t;

	// address width, never below one bit
	function automatic int addr_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cooc_ram.sv =====
`default_nettype none

module cooc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = cooc_pkg::addr_w(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/cooc_index.sv =====
`default_nettype none

// Two-stage pair index: lo*(2H-lo-1)/2 + (hi-lo-1), needs lo < hi.
module cooc_index #(
	parameter int HASH_BITS = cooc_pkg::HASH_BITS_DEF,
	localparam int POS_W  = cooc_pkg::addr_w(HASH_BITS),
	localparam int DEPTH  = HASH_BITS * (HASH_BITS - 1) / 2,
	localparam int ADDR_W = cooc_pkg::addr_w(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_query,
	input  wire logic [POS_W-1:0]    lo,
	input  wire logic [POS_W-1:0]    hi,
	output      cooc_pkg::idx_stat_t stat,
	output      logic [ADDR_W-1:0]   addr
);

	localparam int PROD_W = $clog2(2 * HASH_BITS * HASH_BITS);

	logic [PROD_W-1:0] lo_w;
	logic [PROD_W-1:0] span;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-2:0] sum;

	logic              v_s1, v_s2;
	logic              q_s1, q_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [POS_W-1:0]  off_s1;
	logic [ADDR_W-1:0] addr_s2;

	assign lo_w = PROD_W'(lo);
	assign span = PROD_W'(2 * HASH_BITS - 1) - lo_w;
	assign prod = lo_w * span;

	// row base is prod/2 (prod is always even)
	assign sum = prod_s1[PROD_W-1:1] + (PROD_W-1)'(off_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			q_s1 <= 1'b0;
			q_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			q_s1 <= in_query;
			q_s2 <= q_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		off_s1  <= hi - lo - POS_W'(1);
		addr_s2 <= sum[ADDR_W-1:0];
	end

	assign stat.valid = v_s2;
	assign stat.query = q_s2;
	assign stat.busy  = v_s1 | v_s2;
	assign addr       = addr_s2;

endmodule

`default_nettype wire

// ===== hdl/bit_pair_cooccurrence_counter.sv =====
`default_nettype none

// Bit-pair co-occurrence counter.
// One 8-bit saturating counter per unordered pair of hash bit positions,
// kept in a single-port-write / single-port-read RAM as a packed triangle.
// Input stream (s_*): tuser = mode (0 update, 1 query). An update transaction
// brings the hash in tdata; a query transaction names two positions.
// Output stream (m_*): exactly one transaction per input, pair_count in tdata;
// updates and invalid queries (equal or out-of-range positions) return 0.
// Update: the result is posted at accept; then a scan shifts the hash into a
// position list, then one counter read-modify-write per cycle for each of the
// k(k-1)/2 pairs of k set bits, with a row step before each row and a drain.
// The counter RAM port sets the pace.
// Query: index multiply, add, then counter RAM read.
// Reset: a clearing pass writes zero to all H(H-1)/2 counters with s_tready low.
// Stall: a result waits in the output register; a new input is taken once the
// block is idle and that register is empty or being drained.
module bit_pair_cooccurrence_counter #(
	parameter int HASH_BITS = cooc_pkg::HASH_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output      logic                         s_tready,
	// word0, word1, word2, word3, pos_first, pos_second
	input  wire logic [cooc_pkg::TDATA_W-1:0] s_tdata,
	// mode
	input  wire logic [cooc_pkg::TUSER_W-1:0] s_tuser,
	output      logic                         m_tvalid,
	input  wire logic                         m_tready,
	// pair_count
	output      logic [cooc_pkg::COUNT_W-1:0] m_tdata
);

	localparam int POS_W   = cooc_pkg::addr_w(HASH_BITS);
	localparam int CNT_W   = POS_W + 1;
	localparam int DEPTH   = HASH_BITS * (HASH_BITS - 1) / 2;
	localparam int ADDR_W  = cooc_pkg::addr_w(DEPTH);
	localparam int FP_W    = cooc_pkg::FIELD_POS_W;
	localparam int FW1     = FP_W + 1;
	localparam int POS_LSB = cooc_pkg::NUM_WORDS * cooc_pkg::WORD_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ROW,
		S_PAIR,
		S_QUERY,
		S_DRAIN
	} state_t;

	state_t                       state_q;
	logic [ADDR_W-1:0]            clr_q;
	logic [POS_W-1:0]             bit_q;
	logic [CNT_W-1:0]             n_q;
	logic [POS_W-1:0]             last_q;
	logic [POS_W-1:0]             x_q;
	logic [POS_W-1:0]             y_q;
	logic [POS_W-1:0]             lo_q;
	logic [POS_W-1:0]             qhi_q;
	logic                         first_q;
	logic                         out_v_q;
	logic [cooc_pkg::COUNT_W-1:0] out_data_q;
	logic [HASH_BITS-1:0]         hash_q;

	logic                         v_p_s1;
	logic [POS_W-1:0]             lo_s1;
	logic                         v_s4;
	logic                         q_s4;
	logic [ADDR_W-1:0]            addr_s4;

	logic                         in_acc;
	logic                         post_now;
	logic [FP_W-1:0]              fld_a, fld_b;
	logic                         q_ok;
	logic [FP_W-1:0]              q_lo, q_hi;
	logic [CNT_W-1:0]             n_next;
	logic [POS_W-1:0]             lo_cur;
	logic                         pipe_empty;

	logic                         pos_we;
	logic [POS_W-1:0]             pos_raddr;
	logic [POS_W-1:0]             pos_rdata;

	logic                         idx_in_v;
	logic [POS_W-1:0]             idx_lo, idx_hi;
	cooc_pkg::idx_stat_t          idx_stat;
	logic [ADDR_W-1:0]            idx_addr;

	logic                         cnt_we;
	logic [ADDR_W-1:0]            cnt_waddr;
	logic [cooc_pkg::COUNT_W-1:0] cnt_wdata;
	logic [cooc_pkg::COUNT_W-1:0] cnt_rdata;

	// ---- input decode
	assign s_tready = (state_q == S_IDLE) && (!out_v_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;
	assign fld_a    = s_tdata[POS_LSB +: FP_W];
	assign fld_b    = s_tdata[POS_LSB + FP_W +: FP_W];
	assign q_ok     = ({1'b0, fld_a} < FW1'(HASH_BITS)) &&
	                  ({1'b0, fld_b} < FW1'(HASH_BITS)) && (fld_a != fld_b);
	assign q_lo     = (fld_a < fld_b) ? fld_a : fld_b;
	assign q_hi     = (fld_a < fld_b) ? fld_b : fld_a;
	// updates and invalid queries answer right at accept
	assign post_now = (s_tuser[0] == cooc_pkg::MODE_UPDATE) || !q_ok;

	// ---- scan and pair sequencing
	assign n_next     = n_q + CNT_W'(hash_q[0]);
	assign lo_cur     = first_q ? pos_rdata : lo_q;
	assign pipe_empty = !v_p_s1 && !idx_stat.busy && !v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			bit_q      <= '0;
			n_q        <= '0;
			last_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			lo_q       <= '0;
			qhi_q      <= '0;
			first_q    <= 1'b0;
			out_v_q    <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (m_tvalid && m_tready && !(in_acc && post_now)) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						unique case (s_tuser[0])
							cooc_pkg::MODE_UPDATE: begin
								out_v_q    <= 1'b1;
								out_data_q <= '0;
								bit_q      <= '0;
								n_q        <= '0;
								state_q    <= S_SCAN;
							end
							cooc_pkg::MODE_QUERY: begin
								if (q_ok) begin
									lo_q    <= q_lo[POS_W-1:0];
									qhi_q   <= q_hi[POS_W-1:0];
									state_q <= S_QUERY;
								end else begin
									out_v_q    <= 1'b1;
									out_data_q <= '0;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					n_q   <= n_next;
					bit_q <= bit_q + POS_W'(1);
					if (bit_q == POS_W'(HASH_BITS - 1)) begin
						x_q <= '0;
						if (n_next < CNT_W'(2)) begin
							state_q <= S_DRAIN;
						end else begin
							last_q  <= POS_W'(n_next - CNT_W'(1));
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					// pos[x] read now, arrives in first S_PAIR cycle
					y_q     <= x_q + POS_W'(1);
					first_q <= 1'b1;
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					lo_q    <= lo_cur;
					first_q <= 1'b0;
					if (y_q == last_q) begin
						if (x_q + POS_W'(1) == last_q) begin
							state_q <= S_DRAIN;
						end else begin
							x_q     <= x_q + POS_W'(1);
							state_q <= S_ROW;
						end
					end else begin
						y_q <= y_q + POS_W'(1);
					end
				end
				S_QUERY: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (v_s4 && q_s4) begin
				out_v_q    <= 1'b1;
				out_data_q <= cnt_rdata;
			end
		end
	end

	// hash shifts out one bit per scan cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hash_q <= s_tdata[HASH_BITS-1:0];
		end else if (state_q == S_SCAN) begin
			hash_q <= hash_q >> 1;
		end
	end

	// ---- pipeline valids: pos read (s1), counter read (s4)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p_s1 <= 1'b0;
			v_s4   <= 1'b0;
			q_s4   <= 1'b0;
		end else begin
			v_p_s1 <= (state_q == S_PAIR);
			v_s4   <= idx_stat.valid;
			q_s4   <= idx_stat.query;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1   <= lo_cur;
		addr_s4 <= idx_addr;
	end

	// ---- set-bit position list
	assign pos_we    = (state_q == S_SCAN) && hash_q[0];
	assign pos_raddr = (state_q == S_ROW) ? x_q : y_q;

	cooc_ram #(
		.WIDTH (POS_W),
		.DEPTH (HASH_BITS)
	) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (n_q[POS_W-1:0]),
		.wdata (bit_q),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// ---- pair index
	assign idx_in_v = v_p_s1 || (state_q == S_QUERY);
	assign idx_lo   = v_p_s1 ? lo_s1 : lo_q;
	assign idx_hi   = v_p_s1 ? pos_rdata : qhi_q;

	cooc_index #(
		.HASH_BITS (HASH_BITS)
	) u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (idx_in_v),
		.in_query (!v_p_s1),
		.lo       (idx_lo),
		.hi       (idx_hi),
		.stat     (idx_stat),
		.addr     (idx_addr)
	);

	// ---- counter RAM; pairs within one update are distinct, so no forwarding
	always_comb begin
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = v_s4 && !q_s4;
			cnt_waddr = addr_s4;
			cnt_wdata = (cnt_rdata == cooc_pkg::COUNT_MAX) ? cnt_rdata :
			            cnt_rdata + cooc_pkg::COUNT_W'(1);
		end
	end

	cooc_ram #(
		.WIDTH (cooc_pkg::COUNT_W),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (idx_addr),
		.rdata (cnt_rdata)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
